### rtl/packbits_run_length_decoder_core_macros.svh
// assertion macros for the checker file of the packbits decoder
// no dependencies; clock and reset are passed in by the caller
`ifndef PACKBITS_RUN_LENGTH_DECODER_CORE_MACROS_SVH
`define PACKBITS_RUN_LENGTH_DECODER_CORE_MACROS_SVH

// clocked check, switched off while reset is held
`define PBRLD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbrld check failed");

// clocked check that also holds during reset
`define PBRLD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pbrld check failed");

`endif

### rtl/pbrld_pkg.sv
// types, codes and microcode table of the packbits run-length decoder
// no dependencies; used by the core and its checker
package pbrld_pkg;

  localparam int OBPR = 8;  // decoded bytes packed into one result

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [7:0] END_MARK = 8'd128;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } pbrld_in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [1:0]  status;
    logic        last;
  } pbrld_out_t;

  typedef enum logic [2:0] {
    PH_LEN, PH_LIT, PH_REP, PH_ENDED, PH_DONE, PH_FAIL
  } phase_t;

  // microcode addresses
  typedef enum logic [2:0] {
    UA_FETCH, UA_ERR, UA_OK, UA_LEN, UA_MARK, UA_LIT, UA_REP_CNT, UA_REP
  } uaddr_t;

  typedef enum logic [2:0] {
    EMIT_NONE, EMIT_LIT, EMIT_REP, EMIT_MARK, EMIT_OK, EMIT_ERR
  } emit_t;

  typedef enum logic [1:0] {
    REM_HOLD, REM_LOAD, REM_DEC_LIT, REM_DEC_REP
  } rem_op_t;

  typedef enum logic [2:0] {
    PHO_KEEP, PHO_FAIL, PHO_DONE, PHO_ENDED, PHO_FROM_LEN, PHO_LEN_IF_ZERO
  } ph_op_t;

  typedef enum logic [1:0] {
    BR_JUMP, BR_DISPATCH, BR_LOOP
  } br_t;

  typedef struct packed {
    logic    accept;
    emit_t   emit;
    logic    inc_cnt;
    rem_op_t rem_op;
    ph_op_t  ph_op;
    br_t     br;
    uaddr_t  tgt;
  } uc_t;

  // control store: one word per step
  function automatic uc_t uc_rom(input uaddr_t addr);
    uc_t w;
    w = '{accept: 1'b0, emit: EMIT_NONE, inc_cnt: 1'b0, rem_op: REM_HOLD,
          ph_op: PHO_KEEP, br: BR_JUMP, tgt: UA_FETCH};
    unique case (addr)
      UA_FETCH: begin
        w.accept = 1'b1;
        w.br     = BR_DISPATCH;
      end
      UA_ERR: begin
        w.emit  = EMIT_ERR;
        w.ph_op = PHO_FAIL;
      end
      UA_OK: begin
        w.emit  = EMIT_OK;
        w.ph_op = PHO_DONE;
      end
      UA_LEN: begin
        w.inc_cnt = 1'b1;
        w.rem_op  = REM_LOAD;
        w.ph_op   = PHO_FROM_LEN;
      end
      UA_MARK: begin
        w.inc_cnt = 1'b1;
        w.emit    = EMIT_MARK;
        w.ph_op   = PHO_ENDED;
      end
      UA_LIT: begin
        w.inc_cnt = 1'b1;
        w.emit    = EMIT_LIT;
        w.rem_op  = REM_DEC_LIT;
        w.ph_op   = PHO_LEN_IF_ZERO;
      end
      UA_REP_CNT: begin
        w.inc_cnt = 1'b1;
        w.tgt     = UA_REP;
      end
      UA_REP: begin
        w.emit   = EMIT_REP;
        w.rem_op = REM_DEC_REP;
        w.ph_op  = PHO_LEN_IF_ZERO;
        w.br     = BR_LOOP;
        w.tgt    = UA_REP;
      end
      default: begin
        w.accept = 1'b1;
        w.br     = BR_DISPATCH;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/packbits_run_length_decoder_core.sv
// packbits / run-length decode core: microcoded sequencer and datapath
// depends on pbrld_pkg
// usage:
//   input channel: one request per compressed byte (command 0) or an
//   end-of-input request (command 1); accepted when in_valid is high and
//   in_stall is low. in_stall is low only while the sequencer sits in its
//   fetch step, so one request is worked on at a time.
//   output channel: registered results, each up to eight decoded bytes with
//   byte_count, status and last; taken when out_valid high and out_stall low.
//   cfg port: cfg_wr_en writes input_limit (negative means no limit);
//   write only while the block is idle.
// steps (one microcode word per cycle unless a step waits): each request runs
//   the fetch step, then a length byte the length step, a literal byte the
//   literal step, the end marker the mark step, end-of-input and errors the
//   ok or error step, a repeat run a count and a repeat step per up to eight
//   bytes, an ignored byte none. a result appears the cycle after its step.
// stall: a step that makes a result waits while the output register holds
//   a result the receiver has not taken; the sequencer holds its step.
// reset: synchronous, active low; phase back to expecting a length byte,
//   run count and byte counter zero, limit -1, output register empty.
module packbits_run_length_decoder_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pbrld_pkg::pbrld_in_t    in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pbrld_pkg::pbrld_out_t   out_data,
  input  logic                    cfg_wr_en,
  input  logic signed [31:0]      cfg_wr_data
);
  import pbrld_pkg::*;

  // sequencer state
  uaddr_t     upc_r, upc_nxt;
  uc_t        uc;
  uaddr_t     disp_addr;
  logic       fire;
  logic       out_free;

  // datapath registers
  pbrld_in_t  item_r, item_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] limit_r;
  logic       out_valid_r, out_valid_nxt;
  pbrld_out_t out_data_r, out_data_nxt;

  // datapath helpers
  logic       limit_hit;
  logic [3:0] rep_cnt;
  logic [7:0] rep_left;
  logic [7:0] lit_left;
  logic [7:0] len_value;
  logic [63:0] rep_word;
  pbrld_out_t result;

  assign uc       = uc_rom(upc_r);
  assign out_free = !out_valid_r || !out_stall;

  // a step runs once its request arrives or its result has room; any other step always runs
  always_comb begin
    if (uc.accept) begin
      fire = in_valid;
    end else if (uc.emit != EMIT_NONE) begin
      fire = out_free;
    end else begin
      fire = 1'b1;
    end
  end

  assign in_stall  = !uc.accept;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input limit check against bytes already consumed
  assign limit_hit = !limit_r[31] && (cnt_r >= limit_r);

  // dispatch on the incoming request and the current phase
  always_comb begin
    if (phase_r == PH_FAIL) begin
      disp_addr = UA_ERR;
    end else if (in_data.command) begin
      disp_addr = (phase_r == PH_ENDED || phase_r == PH_DONE) ? UA_OK : UA_ERR;
    end else if (phase_r == PH_ENDED || phase_r == PH_DONE) begin
      disp_addr = UA_FETCH;  // data after the end marker is dropped
    end else if (limit_hit) begin
      disp_addr = UA_ERR;
    end else if (phase_r == PH_LIT) begin
      disp_addr = UA_LIT;
    end else if (phase_r == PH_REP) begin
      disp_addr = UA_REP_CNT;
    end else if (in_data.data_byte == END_MARK) begin
      disp_addr = UA_MARK;
    end else begin
      disp_addr = UA_LEN;
    end
  end

  // repeat chunk: up to OBPR copies of the byte
  assign rep_cnt  = (remaining_r >= 8'(OBPR)) ? 4'(OBPR) : remaining_r[3:0];
  assign rep_left = remaining_r - 8'(rep_cnt);
  assign lit_left = remaining_r - 8'd1;
  // 0..127 gives L+1, 129..255 gives 257-L
  assign len_value = item_r.data_byte[7] ? 8'(9'd257 - {1'b0, item_r.data_byte})
                                         : item_r.data_byte + 8'd1;

  always_comb begin
    rep_word = '0;
    for (int i = 0; i < OBPR; i++) begin
      if (4'(i) < rep_cnt) begin
        rep_word[8*i +: 8] = item_r.data_byte;
      end
    end
  end

  // result formed by the current step
  always_comb begin
    result = '{out_bytes: '0, byte_count: 4'd0, status: ST_ERR, last: 1'b1};
    case (uc.emit)
      EMIT_LIT: begin
        result.out_bytes  = 64'(item_r.data_byte);
        result.byte_count = 4'd1;
        result.status     = ST_DATA;
      end
      EMIT_REP: begin
        result.out_bytes  = rep_word;
        result.byte_count = rep_cnt;
        result.status     = ST_DATA;
        result.last       = (rep_left == 8'd0);
      end
      EMIT_MARK: result.status = ST_MARK;
      EMIT_OK:   result.status = ST_OK;
      default:   result.status = ST_ERR;
    endcase
  end

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (fire) begin
      unique case (uc.br)
        BR_JUMP:     upc_nxt = uc.tgt;
        BR_DISPATCH: upc_nxt = disp_addr;
        BR_LOOP:     upc_nxt = (rep_left != 8'd0) ? uc.tgt : UA_FETCH;
        default:     upc_nxt = UA_FETCH;
      endcase
    end
  end

  // datapath updates driven by the control word
  always_comb begin
    item_nxt      = item_r;
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fire) begin
      if (uc.accept) begin
        item_nxt = in_data;
      end
      if (uc.inc_cnt && cnt_r != '1) begin
        cnt_nxt = cnt_r + 32'd1;
      end
      case (uc.rem_op)
        REM_LOAD:    remaining_nxt = len_value;
        REM_DEC_LIT: remaining_nxt = lit_left;
        REM_DEC_REP: remaining_nxt = rep_left;
        default:     remaining_nxt = remaining_r;
      endcase
      case (uc.ph_op)
        PHO_FAIL:     phase_nxt = PH_FAIL;
        PHO_DONE:     phase_nxt = PH_DONE;
        PHO_ENDED:    phase_nxt = PH_ENDED;
        PHO_FROM_LEN: phase_nxt = item_r.data_byte[7] ? PH_REP : PH_LIT;
        PHO_LEN_IF_ZERO: begin
          if (uc.rem_op == REM_DEC_REP ? rep_left == 8'd0 : lit_left == 8'd0) begin
            phase_nxt = PH_LEN;
          end
        end
        default: phase_nxt = phase_r;
      endcase
      if (uc.emit != EMIT_NONE) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UA_FETCH;
      phase_r     <= PH_LEN;
      remaining_r <= 8'd0;
      cnt_r       <= 32'd0;
      limit_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= $unsigned(cfg_wr_data);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/pbrld_checker.sv
// port-level checks of the packbits decoder core, bound to its top level
// depends on pbrld_pkg and packbits_run_length_decoder_core_macros.svh
`include "packbits_run_length_decoder_core_macros.svh"

module pbrld_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input pbrld_pkg::pbrld_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input pbrld_pkg::pbrld_out_t out_data
);
  import pbrld_pkg::*;

  // a stalled request holds
  `PBRLD_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_data))

  // a stalled result holds
  `PBRLD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // non-data results carry no bytes and close their request
  `PBRLD_ASSERT(a_ctrl_result, clk, rst_n, out_valid && out_data.status != ST_DATA |-> out_data.byte_count == 4'd0 && out_data.out_bytes == 64'd0 && out_data.last)

  // data results carry between one and eight bytes
  `PBRLD_ASSERT(a_data_count, clk, rst_n, out_valid && out_data.status == ST_DATA |-> out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8)

  // output register is empty right after reset
  `PBRLD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind packbits_run_length_decoder_core pbrld_checker u_pbrld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
